// File: rtl/lmsd_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scan driver package
// Shared widths, event codes and the microcode program of the scan sequencer.
// ----------------------------------------------------------------------------
package lmsd_pkg;

   // Matrix geometry.
   localparam int ROW_COUNT = 8;
   localparam int LINE_BITS = 10;

   // Width of the color masks carried by one line item.
   localparam int MASK_W = 10;

   // Counter widths derived from the geometry.
   localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int COL_W = (LINE_BITS > 1) ? $clog2(LINE_BITS) : 1;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_BITS - 1);

   // Active-low output-enable duty register width.
   localparam int DUTY_W = 8;

   // Pin event codes.
   typedef enum logic [1:0] {
      EV_COLUMN = 2'd0,
      EV_ROW    = 2'd1,
      EV_LATCH  = 2'd2,
      EV_RESET  = 2'd3
   } event_kind_type;

   // One pin event as handed to the output register.
   typedef struct packed {
      event_kind_type kind;
      logic           bit_value;
      logic           blanked;
      logic           last_event;
   } event_type;

   // Sequencer to output stage link.
   typedef struct packed {
      logic      fire;
      event_type ev;
   } seq_out_type;

   // Microcode step addresses.
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE     = 3'd0;
   localparam step_type STEP_COL_RED  = 3'd1;
   localparam step_type STEP_COL_GRN  = 3'd2;
   localparam step_type STEP_COL_BLU  = 3'd3;
   localparam step_type STEP_ROW_ONE  = 3'd4;
   localparam step_type STEP_ROW_ZERO = 3'd5;
   localparam step_type STEP_LATCH    = 3'd6;
   localparam step_type STEP_RESET    = 3'd7;

   // When a step produces an event.
   typedef enum logic [1:0] {
      EMIT_NONE      = 2'd0,
      EMIT_ALWAYS    = 2'd1,
      EMIT_FIRST_ROW = 2'd2
   } emit_type;

   // Where the data line level comes from.
   typedef enum logic [2:0] {
      SRC_ZERO  = 3'd0,
      SRC_ONE   = 3'd1,
      SRC_RED   = 3'd2,
      SRC_GREEN = 3'd3,
      SRC_BLUE  = 3'd4
   } bit_src_type;

   // How the step counter moves on.
   typedef enum logic [1:0] {
      JMP_NEXT     = 2'd0,
      JMP_ALWAYS   = 2'd1,
      JMP_REQ_FUNC = 2'd2,
      JMP_COL_MORE = 2'd3
   } jump_type;

   // One control word.
   typedef struct packed {
      logic           wait_req;
      emit_type       emit;
      event_kind_type kind;
      bit_src_type    src;
      logic           blank;
      logic           last;
      logic           col_step;
      logic           row_adv;
      logic           row_clr;
      jump_type       jump;
      step_type       target;
   } ucode_type;

   // Control store: the scan program, one word per step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{wait_req: 1'b0, emit: EMIT_NONE, kind: EV_COLUMN, src: SRC_ZERO,
            blank: 1'b0, last: 1'b0, col_step: 1'b0, row_adv: 1'b0,
            row_clr: 1'b0, jump: JMP_NEXT, target: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.wait_req = 1'b1;
            w.jump     = JMP_REQ_FUNC;
            w.target   = STEP_RESET;
         end
         STEP_COL_RED: begin
            w.emit = EMIT_ALWAYS;
            w.src  = SRC_RED;
         end
         STEP_COL_GRN: begin
            w.emit = EMIT_ALWAYS;
            w.src  = SRC_GREEN;
         end
         STEP_COL_BLU: begin
            w.emit     = EMIT_ALWAYS;
            w.src      = SRC_BLUE;
            w.col_step = 1'b1;
            w.jump     = JMP_COL_MORE;
            w.target   = STEP_COL_RED;
         end
         STEP_ROW_ONE: begin
            w.emit  = EMIT_FIRST_ROW;
            w.kind  = EV_ROW;
            w.src   = SRC_ONE;
            w.blank = 1'b1;
         end
         STEP_ROW_ZERO: begin
            w.emit    = EMIT_ALWAYS;
            w.kind    = EV_ROW;
            w.blank   = 1'b1;
            w.row_adv = 1'b1;
         end
         STEP_LATCH: begin
            w.emit   = EMIT_ALWAYS;
            w.kind   = EV_LATCH;
            w.blank  = 1'b1;
            w.last   = 1'b1;
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_RESET: begin
            w.emit    = EMIT_ALWAYS;
            w.kind    = EV_RESET;
            w.blank   = 1'b1;
            w.last    = 1'b1;
            w.row_clr = 1'b1;
            w.jump    = JMP_ALWAYS;
            w.target  = STEP_IDLE;
         end
         default: begin
            w.wait_req = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/lmsd_sequencer.sv
// ----------------------------------------------------------------------------
// LED matrix scan sequencer
// Step counter over the microcode store, with the line masks, the column
// counter and the row counter that the control words drive.
// ----------------------------------------------------------------------------
module lmsd_sequencer
   import lmsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [MASK_W-1:0] req_red_bits,
   input  logic [MASK_W-1:0] req_green_bits,
   input  logic [MASK_W-1:0] req_blue_bits,
   input  logic              out_free,
   output seq_out_type       seq_out
);

   step_type          step_ff, step_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [MASK_W-1:0] red_ff, green_ff, blue_ff;
   logic [MASK_W-1:0] red_sh, green_sh, blue_sh;
   ucode_type         uc;
   logic              accept;
   logic              emit_now;
   logic              go;
   logic              bit_level;

   // Current control word.
   assign uc = ucode_rom(step_ff);

   assign req_ready = uc.wait_req;
   assign accept    = req_valid & uc.wait_req;

   // Event production and the stall it may cause.
   always_comb begin
      case (uc.emit)
         EMIT_ALWAYS:    emit_now = 1'b1;
         EMIT_FIRST_ROW: emit_now = (row_ff == '0);
         default:        emit_now = 1'b0;
      endcase
   end

   assign go = uc.wait_req ? req_valid : !(emit_now && !out_free);

   // Data line level: column bits are sent inverted.
   assign red_sh   = red_ff >> col_ff;
   assign green_sh = green_ff >> col_ff;
   assign blue_sh  = blue_ff >> col_ff;

   always_comb begin
      case (uc.src)
         SRC_ONE:   bit_level = 1'b1;
         SRC_RED:   bit_level = ~red_sh[0];
         SRC_GREEN: bit_level = ~green_sh[0];
         SRC_BLUE:  bit_level = ~blue_sh[0];
         default:   bit_level = 1'b0;
      endcase
   end

   assign seq_out.fire          = emit_now && out_free;
   assign seq_out.ev.kind       = uc.kind;
   assign seq_out.ev.bit_value  = bit_level;
   assign seq_out.ev.blanked    = uc.blank;
   assign seq_out.ev.last_event = uc.last;

   // Next step, column and row.
   always_comb begin
      step_in = step_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (go) begin
         case (uc.jump)
            JMP_ALWAYS:   step_in = uc.target;
            JMP_REQ_FUNC: step_in = req_func ? uc.target : STEP_W'(step_ff + 1'b1);
            JMP_COL_MORE: step_in = (col_ff != COL_LAST) ? uc.target
                                                         : STEP_W'(step_ff + 1'b1);
            default:      step_in = STEP_W'(step_ff + 1'b1);
         endcase
         if (uc.col_step) begin
            col_in = (col_ff == COL_LAST) ? '0 : COL_W'(col_ff + 1'b1);
         end
         if (uc.row_clr) begin
            row_in = '0;
         end else if (uc.row_adv) begin
            row_in = (row_ff >= ROW_LAST) ? '0 : ROW_W'(row_ff + 1'b1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         step_ff <= step_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   // Line masks are captured when an item is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red_bits;
         green_ff <= req_green_bits;
         blue_ff  <= req_blue_bits;
      end
   end

   // The column counter is back at the first column whenever a line is done.
   a_col_idle: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_IDLE |-> col_ff == '0)
      else $error("column counter not cleared at idle");

   // The row counter never leaves the matrix.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_LAST)
      else $error("row counter out of range");

   // The final event of an item returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      seq_out.fire && seq_out.ev.last_event |=> step_ff == STEP_IDLE)
      else $error("sequencer did not return to idle after final event");

endmodule

// File: rtl/led_matrix_line_scan_driver.sv
// ----------------------------------------------------------------------------
// LED matrix line scan driver
// Serializes RGB line items into shift-register pin events for a row-scanned
// LED matrix, and holds the output-enable PWM duty register.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid / req_ready  func, red/green/blue bits
//  rsp_      out        rsp_valid / rsp_ready  event kind, level, blank, last
//  csr_      in         csr_wr_en              8-bit PWM duty
//
// A line item is taken in the idle step and then runs one sequencer step per pin
// event (30 column clocks, row select, latch) and one row step that emits
// nothing except on the first row. A reset item runs the reset step and returns
// to idle. The sequencer runs one microcode step per cycle and holds while the
// output register is full. Synchronous reset clears the sequencer, the row
// counter, the output valid flag and the duty register.
// ----------------------------------------------------------------------------
module led_matrix_line_scan_driver
   import lmsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [MASK_W-1:0] req_red_bits,
   input  logic [MASK_W-1:0] req_green_bits,
   input  logic [MASK_W-1:0] req_blue_bits,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_event_kind,
   output logic              rsp_bit_value,
   output logic              rsp_blanked,
   output logic              rsp_last_event,
   input  logic              csr_wr_en,
   input  logic [DUTY_W-1:0] csr_wr_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   event_type         rsp_ev_ff;
   logic [DUTY_W-1:0] enable_pwm_duty_ff, enable_pwm_duty_in;
   logic              out_free;
   seq_out_type       seq_out;

   // Scan sequencer.
   lmsd_sequencer u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_red_bits   (req_red_bits),
      .req_green_bits (req_green_bits),
      .req_blue_bits  (req_blue_bits),
      .out_free       (out_free),
      .seq_out        (seq_out)
   );

   // Output register: free when empty or being drained this cycle.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = seq_out.fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_out.fire) begin
         rsp_ev_ff <= seq_out.ev;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_ev_ff.kind;
   assign rsp_bit_value  = rsp_ev_ff.bit_value;
   assign rsp_blanked    = rsp_ev_ff.blanked;
   assign rsp_last_event = rsp_ev_ff.last_event;

   // Output-enable PWM duty register.
   assign enable_pwm_duty_in = csr_wr_en ? csr_wr_data : enable_pwm_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_pwm_duty_ff <= '0;
      end else begin
         enable_pwm_duty_ff <= enable_pwm_duty_in;
      end
   end

   // Once an item is taken, the block is busy on the following cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an item");

endmodule
